// ===== rtl/hrpd_pkg.sv =====
package hrpd_pkg;

    // default configuration of the block
    localparam int DEF_NUM_CHANNELS  = 2;
    localparam int DEF_PAYLOAD_BYTES = 10;

    // payload bytes carried by one input word
    localparam int IN_BYTES = 10;
    localparam int IN_W     = IN_BYTES * 8;

    // accepted heart rate window, plus the special rate of one
    localparam logic [7:0] RATE_MIN  = 8'd30;
    localparam logic [7:0] RATE_MAX  = 8'd240;
    localparam logic [7:0] RATE_ONE  = 8'd1;

    // 60 * 1024 in Q16.8
    localparam logic [23:0] RATE_NUMER = 24'd15728640;

    localparam int QUO_W = 24;
    localparam int DEN_W = 16;

    // byte offsets, channel 0 (pod mode adds POD_SHIFT)
    localparam logic [3:0] OFF0_HR   = 4'd0;
    localparam logic [3:0] OFF0_SEQ  = 4'd1;
    localparam logic [3:0] OFF0_TIME = 4'd2;
    localparam logic [3:0] OFF0_PREV = 4'd4;
    localparam logic [3:0] POD_SHIFT = 4'd4;
    // byte offsets, channel 1
    localparam logic [3:0] OFF1_HR   = 4'd7;
    localparam logic [3:0] OFF1_SEQ  = 4'd6;
    localparam logic [3:0] OFF1_TIME = 4'd4;

    // register map (word index)
    localparam logic REG_POD_MODE = 1'b0;

    typedef enum logic [1:0] {
        STAT_NEW      = 2'd0,
        STAT_BAD_RATE = 2'd1,
        STAT_DUP      = 2'd2,
        STAT_IGNORED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic eval;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/hrpd_div.sv =====
module hrpd_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [hrpd_pkg::QUO_W-1:0] numer,
    input  logic [hrpd_pkg::DEN_W-1:0] denom,
    output logic                       busy,
    output logic [hrpd_pkg::QUO_W-1:0] quotient
);
    import hrpd_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = numer;
            den_next  = denom;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/hrpd_ctrl.sv =====
module hrpd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  hrpd_pkg::sts_t sts,
    output hrpd_pkg::cmd_t cmd
);
    import hrpd_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = sts.need_div ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.load_in   = s_axis_tvalid;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            ST_OUT: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_div_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && !sts.div_busy |=> state_reg == ST_OUT)
        else $error("divider finished but no result was written");

    a_eval_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> cmd.eval)
        else $error("accepted word not evaluated in the next cycle");

endmodule

// ===== rtl/hrpd_dp.sv =====
module hrpd_dp #(
    parameter int NUM_CHANNELS  = hrpd_pkg::DEF_NUM_CHANNELS,
    parameter int PAYLOAD_BYTES = hrpd_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      pod_mode,
    input  logic [hrpd_pkg::IN_W-1:0] s_axis_tdata,
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [63:0]               m_axis_tdata,
    output logic [2:0]                m_axis_tuser,
    input  hrpd_pkg::cmd_t            cmd,
    output hrpd_pkg::sts_t            sts
);
    import hrpd_pkg::*;

    localparam int PAY_W = PAYLOAD_BYTES * 8;

    // input word register
    logic            in_ch_reg;
    logic            in_bc_reg;
    logic [IN_W-1:0] in_pay_reg;

    // per-channel history, cleared at reset
    logic [NUM_CHANNELS-1:0][PAY_W-1:0] last_pay_reg, last_pay_next;
    logic [NUM_CHANNELS-1:0][15:0]      last_beat_reg, last_beat_next;
    logic [NUM_CHANNELS-1:0][7:0]       last_seq_reg, last_seq_next;

    // result fields held between evaluation and output
    status_t     res_status_reg;
    logic        res_ch_reg;
    logic [7:0]  res_seq_reg;
    logic [7:0]  res_hr_reg;
    logic [15:0] res_time_reg;
    logic        res_bad_seq_reg;
    logic        res_bad_old_reg;
    logic        res_div_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg;
    logic [2:0]  m_user_reg;

    logic        ch_valid;
    logic        ch_idx;
    logic [3:0]  hr_off, seq_off, time_off, prev_off;
    logic [7:0]  hr_c, seq_c;
    logic [15:0] time_c, prev_c, delta_c;
    logic        rate_ok, dup_c, bad_seq_c, bad_old_c, need_div_c;
    status_t     status_c;
    logic [QUO_W-1:0] div_numer, div_quo;
    logic             div_busy;
    logic [QUO_W-1:0] rate_out;

    function automatic logic [7:0] byte_at(input logic [IN_W-1:0] p, input logic [3:0] off);
        logic [7:0] b;
        b = 8'd0;
        if (int'(off) < PAYLOAD_BYTES) begin
            b = p[{off, 3'b000} +: 8];
        end
        return b;
    endfunction

    always_comb begin
        ch_valid = in_bc_reg && (int'(in_ch_reg) < NUM_CHANNELS);
        ch_idx   = (NUM_CHANNELS > 1) ? in_ch_reg : 1'b0;
        if (!in_ch_reg) begin
            hr_off   = pod_mode ? OFF0_HR   + POD_SHIFT : OFF0_HR;
            seq_off  = pod_mode ? OFF0_SEQ  + POD_SHIFT : OFF0_SEQ;
            time_off = pod_mode ? OFF0_TIME + POD_SHIFT : OFF0_TIME;
            prev_off = pod_mode ? OFF0_PREV + POD_SHIFT : OFF0_PREV;
        end else begin
            hr_off   = OFF1_HR;
            seq_off  = OFF1_SEQ;
            time_off = OFF1_TIME;
            prev_off = OFF0_PREV;
        end
        hr_c   = byte_at(in_pay_reg, hr_off);
        seq_c  = byte_at(in_pay_reg, seq_off);
        time_c = {byte_at(in_pay_reg, time_off + 4'd1), byte_at(in_pay_reg, time_off)};
        prev_c = {byte_at(in_pay_reg, prev_off + 4'd1), byte_at(in_pay_reg, prev_off)};

        rate_ok   = (hr_c == RATE_ONE) || (hr_c >= RATE_MIN && hr_c <= RATE_MAX);
        dup_c     = in_pay_reg[PAY_W-1:0] == last_pay_reg[ch_idx];
        delta_c   = time_c - last_beat_reg[ch_idx];
        bad_seq_c = seq_c != (last_seq_reg[ch_idx] + 8'd1);
        bad_old_c = !in_ch_reg && (prev_c != last_beat_reg[ch_idx]);

        if (!ch_valid) begin
            status_c = STAT_IGNORED;
        end else if (!rate_ok) begin
            status_c = STAT_BAD_RATE;
        end else if (dup_c) begin
            status_c = STAT_DUP;
        end else begin
            status_c = STAT_NEW;
        end
        need_div_c = (status_c == STAT_NEW) && (delta_c != 16'd0);
        // rounding to nearest: add half the divisor to the numerator
        div_numer  = RATE_NUMER + QUO_W'(delta_c[15:1]);
    end

    always_comb begin
        last_pay_next  = last_pay_reg;
        last_beat_next = last_beat_reg;
        last_seq_next  = last_seq_reg;
        if (cmd.eval && status_c == STAT_NEW) begin
            last_pay_next[ch_idx]  = in_pay_reg[PAY_W-1:0];
            last_beat_next[ch_idx] = time_c;
            last_seq_next[ch_idx]  = seq_c;
        end
    end

    hrpd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.eval && need_div_c),
        .numer    (div_numer),
        .denom    (delta_c),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb begin
        rate_out     = res_div_reg ? div_quo : '0;
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pay_reg  <= '0;
            last_beat_reg <= '0;
            last_seq_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            last_pay_reg  <= last_pay_next;
            last_beat_reg <= last_beat_next;
            last_seq_reg  <= last_seq_next;
            m_valid_reg   <= m_valid_next;
        end
        if (cmd.load_in) begin
            in_ch_reg  <= s_axis_tuser[0];
            in_bc_reg  <= s_axis_tuser[1];
            in_pay_reg <= s_axis_tdata;
        end
        if (cmd.eval) begin
            res_status_reg  <= status_c;
            res_ch_reg      <= in_ch_reg;
            res_seq_reg     <= ch_valid ? seq_c  : 8'd0;
            res_hr_reg      <= ch_valid ? hr_c   : 8'd0;
            res_time_reg    <= ch_valid ? time_c : 16'd0;
            res_bad_seq_reg <= (status_c == STAT_NEW) && bad_seq_c;
            res_bad_old_reg <= (status_c == STAT_NEW) && bad_old_c;
            res_div_reg     <= need_div_c;
        end
        if (cmd.load_out) begin
            m_data_reg <= {6'd0, res_bad_old_reg, res_bad_seq_reg, rate_out,
                           res_time_reg, res_hr_reg, res_seq_reg};
            m_user_reg <= {res_ch_reg, res_status_reg};
        end
    end

    assign sts.need_div  = need_div_c;
    assign sts.div_busy  = div_busy;
    assign sts.out_free  = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_start_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |-> !div_busy)
        else $error("division started while divider busy");

    a_history_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval && status_c != STAT_NEW |=> $stable(last_beat_reg) && $stable(last_seq_reg))
        else $error("channel history changed on a rejected word");

endmodule

// ===== rtl/heart_rate_page_decoder.sv =====
// path: ignored, rejected or duplicate words and new beats with an unchanged
//   beat time go from evaluation to the output register; other new beats first
//   pass the 24-step shift-subtract divider computing the interval rate
// throughput: one word at a time, taken only once the last result is written
// reset: aresetn synchronous active low; clears pod_mode, channel history
//   (payload, beat time, sequence) and the handshake state
module heart_rate_page_decoder #(
    parameter int NUM_CHANNELS  = hrpd_pkg::DEF_NUM_CHANNELS,
    parameter int PAYLOAD_BYTES = hrpd_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // byte0 .. byte9, byte0 lowest
    input  logic [1:0]  s_axis_tuser,  // channel, is_broadcast

    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // sequence_res, reported_rate, beat_time,
                                       // interval_rate, bad_sequence,
                                       // bad_previous_time, zero pad
    output logic [2:0]  m_axis_tuser   // status (2 bits), chan_out
);
    import hrpd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic pod_mode_reg, pod_mode_next;
    logic cfg_wr;
    logic reg_sel;

    // register decode: paddr[2] selects the word; only word 0 holds a register
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        pod_mode_next = pod_mode_reg;
        if (cfg_wr && reg_sel == REG_POD_MODE) begin
            pod_mode_next = pwdata[0];
        end
    end

    // read back, unmapped addresses read zero
    always_comb begin
        prdata = 32'd0;
        if (reg_sel == REG_POD_MODE) begin
            prdata = {31'd0, pod_mode_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pod_mode_reg <= 1'b0;
        end else begin
            pod_mode_reg <= pod_mode_next;
        end
    end

    // sequencer: idle, evaluate, divide, write result
    hrpd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // field pick, checks, channel history, divider and output register
    hrpd_dp #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pod_mode      (pod_mode_reg),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== bench/heart_rate_page_decoder_test.sv =====
module heart_rate_page_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrpd_pkg::*;

    // one payload, byte i at [i], byte0 in the low bits when flattened
    typedef logic [9:0][7:0] page_t;

    // one decoded result, as the block should report it
    typedef struct packed {
        status_t     status;
        logic        chan;
        logic [7:0]  seq_byte;
        logic [7:0]  hr_byte;
        logic [15:0] beat;
        logic [23:0] irate;
        logic        bad_seq;
        logic        bad_prev;
    } beat_result_t;

    localparam logic [2:0] POD_MODE_ADDR = 3'(4 * REG_POD_MODE);
    localparam int PHASE_WORDS = 325;

    // tracks per-channel beat history and the results still owed by the block
    class beat_scoreboard;
        bit           pod_mode = 1'b0;
        page_t        last_page [2] = '{default: '0};
        logic [15:0]  last_beat [2] = '{default: '0};
        logic [7:0]   last_seq  [2] = '{default: '0};
        beat_result_t pending [$];
        int           errors = 0;
        int           seen_status [4] = '{default: 0};

        task report(string msg);
            if (errors < 40)
                $display("  mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task cmp(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // decode an accepted word and queue the result it must produce
        function void note_word(logic ch, logic bc, page_t p);
            beat_result_t r;
            int unsigned  b;
            int unsigned  d;
            logic [15:0]  prev;
            r = '0;
            r.chan = ch;
            if (!bc) begin
                r.status = STAT_IGNORED;
                pending.push_back(r);
                return;
            end
            if (ch == 1'b0) begin
                b = pod_mode ? POD_SHIFT : 0;
                r.hr_byte  = p[OFF0_HR + b];
                r.seq_byte = p[OFF0_SEQ + b];
                r.beat     = {p[OFF0_TIME + b + 1], p[OFF0_TIME + b]};
                prev       = {p[OFF0_PREV + b + 1], p[OFF0_PREV + b]};
            end else begin
                r.hr_byte  = p[OFF1_HR];
                r.seq_byte = p[OFF1_SEQ];
                r.beat     = {p[OFF1_TIME + 1], p[OFF1_TIME]};
                prev       = '0;
            end
            if (r.hr_byte != RATE_ONE && (r.hr_byte < RATE_MIN || r.hr_byte > RATE_MAX)) begin
                r.status = STAT_BAD_RATE;
            end else if (p == last_page[ch]) begin
                r.status = STAT_DUP;
            end else begin
                r.status = STAT_NEW;
                last_page[ch] = p;
                // previous-beat field only exists on channel 0
                if (ch == 1'b0)
                    r.bad_prev = (prev != last_beat[ch]);
                r.bad_seq = (r.seq_byte != 8'(last_seq[ch] + 8'd1));
                d = 16'(r.beat - last_beat[ch]);
                // 61440 / d in Q16.8, rounded half up; unchanged time gives zero
                if (d != 0)
                    r.irate = 24'((RATE_NUMER + d / 2) / d);
                last_beat[ch] = r.beat;
                last_seq[ch]  = r.seq_byte;
            end
            pending.push_back(r);
        endfunction

        task check_word(logic [63:0] data, logic [2:0] user);
            beat_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("result word %h/%h with nothing pending", user, data));
                return;
            end
            e = pending.pop_front();
            seen_status[e.status]++;
            cmp("status", user[1:0], e.status);
            cmp("chan_out", user[2], e.chan);
            cmp("sequence_res", data[7:0], e.seq_byte);
            cmp("reported_rate", data[15:8], e.hr_byte);
            cmp("beat_time", data[31:16], e.beat);
            cmp("interval_rate", data[55:32], e.irate);
            cmp("bad_sequence", data[56], e.bad_seq);
            cmp("bad_previous_time", data[57], e.bad_prev);
        endtask
    endclass

    // clock, reset and every block input start at known values
    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;  // byte0 .. byte9, byte0 lowest
    logic [1:0]  s_axis_tuser  = '0;  // channel, is_broadcast
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [63:0] m_axis_tdata;        // sequence_res, reported_rate, beat_time,
                                      // interval_rate, bad_sequence,
                                      // bad_previous_time, zero pad
    logic [2:0]  m_axis_tuser;        // status (2 bits), chan_out

    beat_scoreboard sb = new;

    // stimulus bookkeeping
    bit          pod = 1'b0;
    int          words_sent = 0;
    int          broadcasts = 0;
    int          ready_hold = 0;
    logic [15:0] gen_time [2] = '{default: '0};
    logic [7:0]  gen_seq  [2] = '{default: '0};
    page_t       gen_page [2] = '{default: '0};

    heart_rate_page_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: alternating stall and ready runs of random length
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            if (m_axis_tready) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(0, 12);
            end else begin
                m_axis_tready <= 1'b1;
                ready_hold    <= $urandom_range(0, 40);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // watch both handshakes; results are checked before new words are noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata);
        end
    end

    // place rate, sequence, beat time and previous time where the channel expects them
    function automatic page_t fill_page(logic ch, bit pm, logic [7:0] hr, logic [7:0] sq,
                                        logic [15:0] t, logic [15:0] prev, page_t p);
        int unsigned b;
        b = pm ? POD_SHIFT : 0;
        if (ch == 1'b0) begin
            p[OFF0_HR + b]       = hr;
            p[OFF0_SEQ + b]      = sq;
            p[OFF0_TIME + b]     = t[7:0];
            p[OFF0_TIME + b + 1] = t[15:8];
            p[OFF0_PREV + b]     = prev[7:0];
            p[OFF0_PREV + b + 1] = prev[15:8];
        end else begin
            p[OFF1_HR]       = hr;
            p[OFF1_SEQ]      = sq;
            p[OFF1_TIME]     = t[7:0];
            p[OFF1_TIME + 1] = t[15:8];
        end
        return p;
    endfunction

    function automatic page_t rnd_page();
        return 80'({$urandom, $urandom, $urandom});
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_page(logic ch, logic bc, page_t p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tuser  <= {bc, ch};
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
        if (bc)
            broadcasts++;
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
    endtask

    task automatic write_pod(bit v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POD_MODE_ADDR;
        pwdata  <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pod         = v;
        sb.pod_mode = v;
    endtask

    // one random word: mostly well-formed beat pages, the rest noise
    task automatic random_word();
        int unsigned pick;
        logic        ch;
        page_t       p;
        logic [7:0]  hr;
        logic [7:0]  sq;
        logic [15:0] dt;
        logic [15:0] prev;
        pick = $urandom_range(0, 99);
        ch   = $urandom_range(0, 1);
        p    = rnd_page();
        if (pick < 65) begin
            // next beat in the channel's running sequence
            hr = ($urandom_range(0, 19) == 0) ? RATE_ONE
                                              : 8'($urandom_range(RATE_MIN, RATE_MAX));
            case ($urandom_range(0, 9))
                0: dt = '0;
                1: dt = 16'd1;
                2: dt = 16'($urandom);
                default: dt = 16'($urandom_range(400, 1600));
            endcase
            sq   = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'(gen_seq[ch] + 8'd1);
            prev = ($urandom_range(0, 19) == 0) ? 16'($urandom) : gen_time[ch];
            p = fill_page(ch, pod, hr, sq, 16'(gen_time[ch] + dt), prev, p);
            gen_time[ch] = 16'(gen_time[ch] + dt);
            gen_seq[ch]  = sq;
            gen_page[ch] = p;
            send_page(ch, 1'b1, p);
        end else if (pick < 75) begin
            // repeat of the last beat page on this channel
            send_page(ch, 1'b1, gen_page[ch]);
        end else if (pick < 83) begin
            // rate outside the window
            hr = $urandom_range(0, 1) ? 8'($urandom_range(0, RATE_MIN - 1))
                                      : 8'($urandom_range(RATE_MAX + 1, 255));
            if (hr == RATE_ONE)
                hr = '0;
            p = fill_page(ch, pod, hr, 8'($urandom), 16'($urandom), 16'($urandom), p);
            send_page(ch, 1'b1, p);
        end else if (pick < 90) begin
            send_page(ch, 1'b0, p);
        end else begin
            send_page(ch, 1'($urandom), p);
        end
    endtask

    initial begin
        page_t       pg;
        int          burst_left;
        int          gap;
        int          start;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words, standard layout
        write_pod(1'b0);
        send_page(1'b0, 1'b0, rnd_page());                  // other event, channel 0
        send_page(1'b1, 1'b0, '1);                          // other event, channel 1
        send_page(1'b0, 1'b1, '0);                          // rate zero
        send_page(1'b0, 1'b1, fill_page(1'b0, 1'b0, 8'd29, 8'd1, 16'd100, '0, '1));
        send_page(1'b0, 1'b1, fill_page(1'b0, 1'b0, 8'd241, 8'd1, 16'd100, '0, '0));
        send_page(1'b0, 1'b1, '1);                          // rate 255
        // lowest rate, beat time unchanged from reset
        pg = fill_page(1'b0, 1'b0, RATE_MIN, 8'd1, 16'd0, 16'd0, '0);
        send_page(1'b0, 1'b1, pg);
        send_page(1'b0, 1'b1, pg);                          // duplicate payload
        // highest rate, one tick interval
        send_page(1'b0, 1'b1, fill_page(1'b0, 1'b0, RATE_MAX, 8'd2, 16'd1, 16'd0, '0));
        // rate one, sequence gap, wrong previous time
        send_page(1'b0, 1'b1, fill_page(1'b0, 1'b0, RATE_ONE, 8'h80, 16'hffff,
                                        16'h1234, '1));
        // beat time wraps past zero
        send_page(1'b0, 1'b1, fill_page(1'b0, 1'b0, 8'd120, 8'h81, 16'h0001,
                                        16'hffff, '0));
        // channel 1: longest interval, then shortest useful one, then repeat
        send_page(1'b1, 1'b1, fill_page(1'b1, 1'b0, RATE_MIN, 8'd1, 16'hffff, '0, '0));
        pg = fill_page(1'b1, 1'b0, RATE_MAX, 8'd2, 16'h00ff, '0, '1);
        send_page(1'b1, 1'b1, pg);
        send_page(1'b1, 1'b1, pg);
        send_page(1'b1, 1'b1, fill_page(1'b1, 1'b0, 8'hff, 8'd3, 16'h0100, '0, '0));
        send_page(1'b1, 1'b1, fill_page(1'b1, 1'b0, RATE_ONE, 8'hff, 16'hffff, '0, '1));

        // directed words, pod layout on channel 0
        drain();
        write_pod(1'b1);
        pg = fill_page(1'b0, 1'b1, 8'd100, 8'h82, 16'h0801, 16'h0001, '0);
        send_page(1'b0, 1'b1, pg);
        send_page(1'b0, 1'b1, pg);
        send_page(1'b0, 1'b1, fill_page(1'b0, 1'b1, 8'd28, 8'h83, 16'h0c01, 16'h0801, '1));
        send_page(1'b1, 1'b0, '1);
        // channel 1 ignores pod mode; sequence wraps to zero
        send_page(1'b1, 1'b1, fill_page(1'b1, 1'b1, 8'd60, 8'h00, 16'h0300, '0,
                                        rnd_page()));

        // random phases, alternating the register between its two settings
        burst_left = 0;
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_pod(ph[0]);
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                if (burst_left == 0) begin
                    // gap before the next burst; zero keeps the stream back to back
                    gap        = $urandom_range(0, 6);
                    burst_left = $urandom_range(1, 24);
                    if (gap > 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end
                // now and then let the block run completely dry
                if ($urandom_range(0, 149) == 0)
                    drain();
                random_word();
                burst_left--;
            end
        end

        // let everything owed come back, then watch for stray results
        drain();
        repeat (40) @(posedge aclk);

        $display("words sent %0d (%0d broadcasts) over both pod settings on both channels",
                 words_sent, broadcasts);
        $display("results: %0d new beats, %0d bad rates, %0d duplicates, %0d ignored",
                 sb.seen_status[STAT_NEW], sb.seen_status[STAT_BAD_RATE],
                 sb.seen_status[STAT_DUP], sb.seen_status[STAT_IGNORED]);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
